// File: rtl/emchk_pkg.sv
// Package: shared types and constants of the e-mail address syntax checker.
`timescale 1ns / 1ps

package emchk_pkg;

   localparam int unsigned LOCAL_MAX_W = 7;

   localparam logic [LOCAL_MAX_W-1:0] LOCAL_MAX_RESET = 7'd64;

   localparam logic [7:0] CHAR_AT     = 8'h40;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_UNDER  = 8'h5F;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   typedef enum logic [1:0] {
      OUTCOME_BLANK   = 2'd0,
      OUTCOME_VALID   = 2'd1,
      OUTCOME_INVALID = 2'd2
   } outcome_type;

   // Character classes of one byte.
   typedef struct packed {
      logic ws;
      logic alnum;
      logic at;
      logic dot;
      logic hyphen;
      logic local_sym;
   } byte_class_type;

endpackage

// File: rtl/email_address_syntax_check.sv
// Top level: e-mail address syntax checker with input, result and limit registers.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------------------
//  req     | in        | req_tvalid/req_tready | tdata: data_byte; tuser: has_byte; tlast
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: outcome in [1:0], zeros above
//  csr     | in        | csr_valid/csr_ready   | csr_data: local_max
//
// One item a cycle is accepted; an item passes the input register, the scanner logic and,
// if it is the last of a value, the result register, from which its result is offered. A
// stalled result stops the input register only when that register holds a last item; other
// items keep flowing. Synchronous reset clears all control state and sets local_max to 64;
// no clearing pass is needed.
`timescale 1ns / 1ps

module email_address_syntax_check (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [7:0] data_byte
   input  logic                                  req_tuser,   // [0] has_byte
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,   // [1:0] outcome, [7:2] zero
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [emchk_pkg::LOCAL_MAX_W-1:0]     csr_data
);
   import emchk_pkg::*;

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_has_ff;
   logic                   in_last_ff;
   logic [LOCAL_MAX_W-1:0] local_max_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   outcome_type            rsp_outcome_ff;

   logic                   step;
   byte_class_type         byte_class;
   outcome_type            outcome;

   // Only a last item needs room in the result register.
   assign step       = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign csr_ready  = 1'b1;

   assign rsp_valid_in = (step && in_last_ff) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         local_max_ff <= LOCAL_MAX_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            local_max_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_has_ff  <= req_tuser;
         in_last_ff <= req_tlast;
      end
      if (step && in_last_ff) begin
         rsp_outcome_ff <= outcome;
      end
   end

   emchk_classify u_classify (
      .data_byte  (in_byte_ff),
      .byte_class (byte_class)
   );

   emchk_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_class (byte_class),
      .has_byte   (in_has_ff),
      .last       (in_last_ff),
      .local_max  (local_max_ff),
      .outcome    (outcome)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_outcome_ff};

   // A last item that leaves the input register always lands in the result register.
   a_last_lands: assert property (@(posedge clock) disable iff (reset)
      (step && in_last_ff) |=> rsp_valid_ff)
      else $error("last item produced no result");

   // A held result may only be overwritten once it has been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(step && in_last_ff))
      else $error("pending result overwritten");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !in_valid_ff))
      else $error("valid flags set after reset");

endmodule

// File: rtl/emchk_classify.sv
// Byte classifier: sorts one byte into the character classes used by the checker.
`timescale 1ns / 1ps

module emchk_classify (
   input  logic [7:0]                data_byte,
   output emchk_pkg::byte_class_type byte_class
);
   import emchk_pkg::*;

   logic is_lower;
   logic is_upper;
   logic is_digit;

   assign is_lower = (data_byte >= 8'h61) && (data_byte <= 8'h7A);
   assign is_upper = (data_byte >= 8'h41) && (data_byte <= 8'h5A);
   assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);

   always_comb begin
      byte_class.ws        = (data_byte == CHAR_SPACE) ||
                             ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR));
      byte_class.alnum     = is_lower || is_upper || is_digit;
      byte_class.at        = (data_byte == CHAR_AT);
      byte_class.dot       = (data_byte == CHAR_DOT);
      byte_class.hyphen    = (data_byte == CHAR_HYPHEN);
      byte_class.local_sym = (data_byte == CHAR_UNDER) || (data_byte == CHAR_PLUS) ||
                             (data_byte == CHAR_HYPHEN);
   end

endmodule

// File: rtl/emchk_scan.sv
// Syntax scanner: holds the per-value state and works out the outcome on the last item.
`timescale 1ns / 1ps

module emchk_scan (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step,
   input  emchk_pkg::byte_class_type              byte_class,
   input  logic                                   has_byte,
   input  logic                                   last,
   input  logic [emchk_pkg::LOCAL_MAX_W-1:0]      local_max,
   output emchk_pkg::outcome_type                 outcome
);
   import emchk_pkg::*;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_LOCAL,
      PH_DOMAIN
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic                   space_pending;
      logic [LOCAL_MAX_W-1:0] local_count;
      logic                   domain_nonempty;
      logic                   prev_was_dot;
      logic                   domain_dotted;
      logic                   bad_seen;
   } scan_state_type;

   localparam scan_state_type STATE_CLEAR = '{
      phase:           PH_LEAD,
      space_pending:   1'b0,
      local_count:     '0,
      domain_nonempty: 1'b0,
      prev_was_dot:    1'b0,
      domain_dotted:   1'b0,
      bad_seen:        1'b0
   };

   scan_state_type state_ff;
   scan_state_type state_upd;
   scan_state_type state_in;

   always_comb begin
      state_upd = state_ff;
      if (has_byte) begin
         if (byte_class.ws) begin
            if (state_ff.phase != PH_LEAD) begin
               state_upd.space_pending = 1'b1;
            end
         end else begin
            // Content after trailing whitespace spoils the value.
            if (state_ff.space_pending) begin
               state_upd.bad_seen = 1'b1;
            end
            unique case (state_ff.phase) inside
               PH_LEAD, PH_LOCAL: begin
                  state_upd.phase = PH_LOCAL;
                  if (byte_class.at) begin
                     if (state_ff.local_count == '0) begin
                        state_upd.bad_seen = 1'b1;
                     end
                     state_upd.phase = PH_DOMAIN;
                  end else begin
                     if (!(byte_class.alnum || byte_class.dot || byte_class.local_sym)) begin
                        state_upd.bad_seen = 1'b1;
                     end
                     // The count saturates at the limit.
                     if (state_ff.local_count >= local_max) begin
                        state_upd.bad_seen = 1'b1;
                     end else begin
                        state_upd.local_count = state_ff.local_count + LOCAL_MAX_W'(1);
                     end
                  end
               end
               PH_DOMAIN: begin
                  if (byte_class.dot) begin
                     if (!state_ff.domain_nonempty || state_ff.prev_was_dot) begin
                        state_upd.bad_seen = 1'b1;
                     end
                     state_upd.domain_dotted = 1'b1;
                     state_upd.prev_was_dot  = 1'b1;
                  end else begin
                     if (!(byte_class.alnum || byte_class.hyphen)) begin
                        state_upd.bad_seen = 1'b1;
                     end
                     state_upd.prev_was_dot = 1'b0;
                  end
                  state_upd.domain_nonempty = 1'b1;
               end
               default: begin
                  state_upd = state_ff;
               end
            endcase
         end
      end
   end

   always_comb begin
      if (state_upd.phase == PH_LEAD) begin
         outcome = OUTCOME_BLANK;
      end else if (!state_upd.bad_seen && (state_upd.phase == PH_DOMAIN) &&
                   state_upd.domain_nonempty && state_upd.domain_dotted &&
                   !state_upd.prev_was_dot && (state_upd.local_count != '0)) begin
         outcome = OUTCOME_VALID;
      end else begin
         outcome = OUTCOME_INVALID;
      end
   end

   assign state_in = last ? STATE_CLEAR : state_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   // Nothing is recorded while only leading whitespace has been seen.
   a_lead_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_LEAD) |->
         (!state_ff.space_pending && !state_ff.bad_seen &&
          (state_ff.local_count == '0)))
      else $error("leading phase holds stale value state");

   // Domain flags stay clear until the at sign has been passed.
   a_domain_flags: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase != PH_DOMAIN) |->
         (!state_ff.domain_nonempty && !state_ff.domain_dotted && !state_ff.prev_was_dot))
      else $error("domain flags set outside the domain part");

   a_dot_order: assert property (@(posedge clock) disable iff (reset)
      state_ff.prev_was_dot |-> (state_ff.domain_dotted && state_ff.domain_nonempty))
      else $error("previous dot flagged without a dot in the domain");

   // A last item returns the scanner to the start of a value.
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (step && last) |=> (state_ff == STATE_CLEAR))
      else $error("state not cleared after the last item");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the e-mail address syntax checker.
`timescale 1ns / 1ps

module tb;
   import emchk_pkg::*;

   typedef enum logic [1:0] {
      SCAN_LEAD   = 2'd0,
      SCAN_LOCAL  = 2'd1,
      SCAN_DOMAIN = 2'd2
   } scan_phase_type;

   typedef logic [7:0] text_type[$];

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 4;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [7:0] data_byte
   logic                   req_tuser;   // [0] has_byte
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;   // [1:0] outcome, [7:2] zero
   logic                   csr_valid;
   logic                   csr_ready;
   logic [LOCAL_MAX_W-1:0] csr_data;

   // Shadow copy of the checker's per-value state and its length limit.
   scan_phase_type         scan_phase;
   logic                   ws_after_text;
   logic [LOCAL_MAX_W-1:0] local_len;
   logic                   domain_has_byte;
   logic                   last_was_dot;
   logic                   domain_has_dot;
   logic                   rule_broken;
   logic [LOCAL_MAX_W-1:0] local_limit;

   outcome_type expected_outcomes[$];
   int          failures = 0;
   int          bytes_sent = 0;
   int          idle_pct = 33;
   int          rsp_hold = 0;
   int          quiet_cycles = 0;

   email_address_syntax_check dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic is_space(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
   endfunction

   task automatic clear_scan();
      scan_phase      = SCAN_LEAD;
      ws_after_text   = 1'b0;
      local_len       = '0;
      domain_has_byte = 1'b0;
      last_was_dot    = 1'b0;
      domain_has_dot  = 1'b0;
      rule_broken     = 1'b0;
   endtask

   // Advances the shadow state by one accepted item and queues the outcome on a last item.
   task automatic scan_item(input logic [7:0] c, input logic has, input logic fin);
      outcome_type verdict;
      if (has) begin
         if (is_space(c)) begin
            if (scan_phase != SCAN_LEAD)
               ws_after_text = 1'b1;
         end else begin
            if (ws_after_text)
               rule_broken = 1'b1;
            if (scan_phase == SCAN_LEAD)
               scan_phase = SCAN_LOCAL;
            if (scan_phase == SCAN_LOCAL) begin
               if (c == CHAR_AT) begin
                  if (local_len == 0)
                     rule_broken = 1'b1;
                  scan_phase = SCAN_DOMAIN;
               end else begin
                  if (!(is_alnum(c) || c == CHAR_DOT || c == CHAR_UNDER ||
                        c == CHAR_PLUS || c == CHAR_HYPHEN))
                     rule_broken = 1'b1;
                  if (local_len >= local_limit)
                     rule_broken = 1'b1;
                  else
                     local_len = local_len + LOCAL_MAX_W'(1);
               end
            end else if (c == CHAR_DOT) begin
               if (!domain_has_byte || last_was_dot)
                  rule_broken = 1'b1;
               domain_has_dot  = 1'b1;
               last_was_dot    = 1'b1;
               domain_has_byte = 1'b1;
            end else begin
               if (!(is_alnum(c) || c == CHAR_HYPHEN))
                  rule_broken = 1'b1;
               last_was_dot    = 1'b0;
               domain_has_byte = 1'b1;
            end
         end
      end
      if (fin) begin
         if (scan_phase == SCAN_LEAD)
            verdict = OUTCOME_BLANK;
         else if (!rule_broken && scan_phase == SCAN_DOMAIN && domain_has_byte &&
                  domain_has_dot && !last_was_dot && local_len != 0)
            verdict = OUTCOME_VALID;
         else
            verdict = OUTCOME_INVALID;
         expected_outcomes.push_back(verdict);
         clear_scan();
      end
   endtask

   // Called and left at a falling edge; valid stays high so the next item can follow at once.
   task automatic send_item(input logic [7:0] c, input logic has, input logic fin);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= has;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      scan_item(c, has, fin);
      if (has)
         bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], 1'b1, i == s.len() - 1);
   endtask

   // Sends a value, sometimes with empty items mixed in or the end marked by an empty item.
   task automatic send_value(input text_type text);
      bit split_last;
      split_last = (text.size() == 0) || ($urandom_range(4) == 0);
      foreach (text[i]) begin
         if ($urandom_range(9) == 0)
            send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         send_item(text[i], 1'b1, !split_last && i == text.size() - 1);
      end
      if (split_last)
         send_item(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_outcomes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_local_limit(input logic [LOCAL_MAX_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      local_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_space();
      if ($urandom_range(1) == 0)
         return CHAR_SPACE;
      return CHAR_TAB + 8'($urandom_range(4));
   endfunction

   function automatic logic [7:0] pick_alnum();
      case ($urandom_range(2))
         0: return "a" + 8'($urandom_range(25));
         1: return "A" + 8'($urandom_range(25));
         default: return "0" + 8'($urandom_range(9));
      endcase
   endfunction

   function automatic logic [7:0] pick_local_char();
      case ($urandom_range(7))
         0: return CHAR_DOT;
         1: return CHAR_UNDER;
         2: return CHAR_PLUS;
         3: return CHAR_HYPHEN;
         default: return pick_alnum();
      endcase
   endfunction

   // Mostly well-formed addresses with random content, some damaged, plus blanks and noise.
   task automatic send_random_value();
      text_type text;
      int kind;
      int n;
      int cap;
      int pos;
      kind = $urandom_range(99);
      if (kind < 70) begin
         repeat ($urandom_range(2)) text.push_back(pick_space());
         cap = (local_limit < 8) ? local_limit : 8;
         if ($urandom_range(9) == 0)
            n = local_limit + $urandom_range(1);
         else
            n = $urandom_range(cap < 1 ? 1 : cap, 1);
         repeat (n) text.push_back(pick_local_char());
         text.push_back(CHAR_AT);
         n = $urandom_range(3, 1);
         for (int lbl = 0; lbl < n; lbl++) begin
            if (lbl != 0)
               text.push_back(CHAR_DOT);
            repeat ($urandom_range(4, 1))
               text.push_back($urandom_range(5) == 0 ? CHAR_HYPHEN : pick_alnum());
         end
         repeat ($urandom_range(2)) text.push_back(pick_space());
         if ($urandom_range(99) < 30) begin
            pos = $urandom_range(text.size() - 1);
            case ($urandom_range(3))
               0: text[pos] = 8'($urandom_range(255));
               1: text.insert(pos, CHAR_DOT);
               2: text.insert(pos, CHAR_AT);
               default: text.insert(pos, pick_space());
            endcase
         end
      end else if (kind < 85) begin
         repeat ($urandom_range(3)) text.push_back(pick_space());
      end else begin
         repeat ($urandom_range(8, 1)) text.push_back(8'($urandom_range(255)));
      end
      send_value(text);
   endtask

   task automatic test_directed();
      send_item(8'h00, 1'b0, 1'b1);
      send_text(" \t");
      send_item(8'h00, 1'b0, 1'b1);
      send_text(" a@b.c ");
      send_text("a@b");
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_text("Q_+-.9@a.b");
      wait_idle();
   endtask

   task automatic test_local_limit();
      write_local_limit('0);
      send_text("a@b.c");
      wait_idle();
      write_local_limit(7'd1);
      send_text("a@b.c");
      send_text("ab@c.d");
      wait_idle();
      write_local_limit(7'd127);
      for (int len = 127; len <= 128; len++) begin
         repeat (len) send_item(pick_alnum(), 1'b1, 1'b0);
         send_text("@y.z");
      end
      wait_idle();
   endtask

   task automatic test_back_to_back();
      int start;
      idle_pct = 0;
      start = bytes_sent;
      while (bytes_sent - start < 120)
         send_random_value();
      wait_idle();
      idle_pct = 33;
   endtask

   // The receiver holds off long enough for the block to stall its input.
   task automatic test_backpressure();
      rsp_hold = 300;
      repeat (30) send_text($urandom_range(1) ? "a@b.c" : "x");
      wait_idle();
   endtask

   task automatic test_random();
      int start;
      int unsigned limits[5];
      limits = '{127, 1, $urandom_range(20, 2), $urandom_range(126, 2), 64};
      foreach (limits[p]) begin
         write_local_limit(limits[p][LOCAL_MAX_W-1:0]);
         start = bytes_sent;
         while (bytes_sent - start < 130)
            send_random_value();
         wait_idle();
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_tready <= !(idle_pct != 0 && $urandom_range(99) < idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t: result with none expected, got outcome %0d", $time, rsp_tdata[1:0]);
            failures++;
         end else begin
            if (rsp_tdata[1:0] != expected_outcomes[0]) begin
               $display("%0t: outcome mismatch, expected %0d, got %0d", $time,
                        expected_outcomes[0], rsp_tdata[1:0]);
               failures++;
            end
            if (rsp_tdata[7:2] != 6'd0) begin
               $display("%0t: padding mismatch, expected 0, got %0d", $time, rsp_tdata[7:2]);
               failures++;
            end
            void'(expected_outcomes.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      local_limit = LOCAL_MAX_RESET;
      clear_scan();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_local_limit();
      test_back_to_back();
      test_backpressure();
      test_random();

      wait_idle();
      repeat (8) @(posedge clock);
      if (expected_outcomes.size() != 0) begin
         $display("%0t: %0d outcomes never arrived", $time, expected_outcomes.size());
         failures++;
      end
      if (failures == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
